FILE: hw/rtl/lcrc_pkg.sv
// Shared types and constants of the link connect retry controller.
`default_nettype none
package lcrc_pkg;

  localparam int unsigned TIME_BITS_DEFAULT = 32;
  localparam int unsigned MS_W              = 32;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_DATA_W        = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DLY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DLY = 3'd4;

  localparam logic [MS_W-1:0] TIMEOUT_RST    = 32'd15000;
  localparam logic [1:0]      MAX_ATT_RST    = 2'd3;
  localparam logic [MS_W-1:0] FIRST_DLY_RST  = 32'd8000;
  localparam logic [MS_W-1:0] SECOND_DLY_RST = 32'd30000;

  typedef enum logic [1:0] {
    MODE_DISABLED   = 2'd0,
    MODE_CONNECTING = 2'd1,
    MODE_ONLINE     = 2'd2,
    MODE_OFFLINE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_START  = 2'd1,
    KIND_RETRY  = 2'd2
  } kind_e;

  typedef struct packed {
    logic            enabled;
    logic [MS_W-1:0] connect_timeout_ms;
    logic [1:0]      max_attempts;
    logic [MS_W-1:0] first_retry_delay_ms;
    logic [MS_W-1:0] second_retry_delay_ms;
  } cfg_t;

  // Control part of the state; the time stamps travel separately.
  typedef struct packed {
    mode_e      mode;
    logic [1:0] attempt_count;
    logic       retry_armed;
  } ctl_t;

  typedef struct packed {
    mode_e      mode;
    logic       start_link;
    logic       just_connected;
    logic       just_disconnected;
    logic [1:0] attempt_number;
    logic       retry_pending;
  } rsp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lcrc_req_if.sv
// Request channel: event kind, millisecond time and link status.
`default_nettype none
interface lcrc_req_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [lcrc_pkg::MS_W-1:0] now_ms;
  logic                   link_up;

  modport source (output valid, kind, now_ms, link_up, input ready);
  modport sink   (input valid, kind, now_ms, link_up, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lcrc_rsp_if.sv
// Result channel: mode, pulses, attempt count and pending bit.
`default_nettype none
interface lcrc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       start_link;
  logic       just_connected;
  logic       just_disconnected;
  logic [1:0] attempt_number;
  logic       retry_pending;

  modport source (output valid, mode, start_link, just_connected, just_disconnected,
                  attempt_number, retry_pending, input ready);
  modport sink   (input valid, mode, start_link, just_connected, just_disconnected,
                  attempt_number, retry_pending, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lcrc_cfg_regs.sv
// Configuration register file with write-only port.
`default_nettype none
module lcrc_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lcrc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [lcrc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output lcrc_pkg::cfg_t                         cfg_o
);

  lcrc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lcrc_pkg::CFG_ENABLED:    cfg_d.enabled               = cfg_wdata_i[0];
        lcrc_pkg::CFG_TIMEOUT:    cfg_d.connect_timeout_ms    = cfg_wdata_i;
        lcrc_pkg::CFG_MAX_ATT:    cfg_d.max_attempts          = cfg_wdata_i[1:0];
        lcrc_pkg::CFG_FIRST_DLY:  cfg_d.first_retry_delay_ms  = cfg_wdata_i;
        lcrc_pkg::CFG_SECOND_DLY: cfg_d.second_retry_delay_ms = cfg_wdata_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled               <= 1'b0;
      cfg_q.connect_timeout_ms    <= lcrc_pkg::TIMEOUT_RST;
      cfg_q.max_attempts          <= lcrc_pkg::MAX_ATT_RST;
      cfg_q.first_retry_delay_ms  <= lcrc_pkg::FIRST_DLY_RST;
      cfg_q.second_retry_delay_ms <= lcrc_pkg::SECOND_DLY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: hw/rtl/lcrc_step.sv
// Next-state and result logic for one request.
`default_nettype none
module lcrc_step #(
  parameter int unsigned TIME_BITS = lcrc_pkg::TIME_BITS_DEFAULT
) (
  input  wire lcrc_pkg::cfg_t             cfg_i,
  input  wire logic [1:0]                 kind_i,
  input  wire logic [lcrc_pkg::MS_W-1:0]  now_ms_i,
  input  wire logic                       link_up_i,
  input  wire lcrc_pkg::ctl_t             ctl_i,
  input  wire logic [TIME_BITS-1:0]       start_time_i,
  input  wire logic [TIME_BITS-1:0]       retry_time_i,
  output lcrc_pkg::ctl_t                  ctl_o,
  output logic [TIME_BITS-1:0]            start_time_o,
  output logic [TIME_BITS-1:0]            retry_time_o,
  output lcrc_pkg::rsp_t                  rsp_o
);

  // Compare width covers both the time range and the 32-bit timeout.
  localparam int unsigned CMP_W = (TIME_BITS > lcrc_pkg::MS_W) ? TIME_BITS : lcrc_pkg::MS_W;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] since_retry;
  logic [TIME_BITS-1:0] auto_delay;
  logic                 timed_out;
  logic                 retry_due;
  logic                 start_link;
  logic                 conn;
  logic                 disc;

  assign now_t       = TIME_BITS'(now_ms_i);
  assign elapsed     = now_t - start_time_i;
  assign since_retry = now_t - retry_time_i;
  assign timed_out   = CMP_W'(elapsed) >= CMP_W'(cfg_i.connect_timeout_ms);
  // Deadline reached when the wrapped difference lies in the lower half.
  assign retry_due   = ~since_retry[TIME_BITS-1];
  // Clamp the delay index to the last delay.
  assign auto_delay  = (ctl_i.attempt_count <= 2'd1) ? TIME_BITS'(cfg_i.first_retry_delay_ms)
                                                     : TIME_BITS'(cfg_i.second_retry_delay_ms);

  always_comb begin
    ctl_o        = ctl_i;
    start_time_o = start_time_i;
    retry_time_o = retry_time_i;
    start_link   = 1'b0;
    conn         = 1'b0;
    disc         = 1'b0;
    case (kind_i)
      lcrc_pkg::KIND_START: begin
        if (!cfg_i.enabled) begin
          ctl_o.mode = lcrc_pkg::MODE_DISABLED;
        end else begin
          ctl_o.attempt_count = 2'd1;
          ctl_o.retry_armed   = 1'b0;
          ctl_o.mode          = lcrc_pkg::MODE_CONNECTING;
          start_time_o        = now_t;
          retry_time_o        = '0;
          start_link          = 1'b1;
        end
      end
      lcrc_pkg::KIND_RETRY: begin
        if (ctl_i.mode == lcrc_pkg::MODE_OFFLINE) begin
          ctl_o.attempt_count = 2'd1;
          ctl_o.retry_armed   = 1'b0;
          ctl_o.mode          = lcrc_pkg::MODE_CONNECTING;
          start_time_o        = now_t;
          retry_time_o        = '0;
          start_link          = 1'b1;
        end
      end
      lcrc_pkg::KIND_UPDATE: begin
        case (ctl_i.mode)
          lcrc_pkg::MODE_CONNECTING: begin
            if (link_up_i) begin
              ctl_o.mode = lcrc_pkg::MODE_ONLINE;
              conn       = 1'b1;
            end else if (timed_out) begin
              ctl_o.mode = lcrc_pkg::MODE_OFFLINE;
              if (ctl_i.attempt_count < cfg_i.max_attempts) begin
                retry_time_o      = now_t + auto_delay;
                ctl_o.retry_armed = 1'b1;
              end else begin
                retry_time_o      = '0;
                ctl_o.retry_armed = 1'b0;
              end
            end
          end
          lcrc_pkg::MODE_ONLINE: begin
            if (!link_up_i) begin
              ctl_o.mode          = lcrc_pkg::MODE_OFFLINE;
              ctl_o.attempt_count = 2'd0;
              ctl_o.retry_armed   = 1'b1;
              retry_time_o        = now_t + TIME_BITS'(cfg_i.first_retry_delay_ms);
              disc                = 1'b1;
            end
          end
          lcrc_pkg::MODE_OFFLINE: begin
            if (link_up_i) begin
              ctl_o.mode = lcrc_pkg::MODE_ONLINE;
              conn       = 1'b1;
            end else if (ctl_i.retry_armed && retry_due) begin
              ctl_o.attempt_count = ctl_i.attempt_count + 2'd1;
              ctl_o.retry_armed   = 1'b0;
              ctl_o.mode          = lcrc_pkg::MODE_CONNECTING;
              start_time_o        = now_t;
              retry_time_o        = '0;
              start_link          = 1'b1;
            end
          end
          default: ; // disabled: hold
        endcase
      end
      default: ; // unknown kind: hold
    endcase
  end

  always_comb begin
    rsp_o.mode              = ctl_o.mode;
    rsp_o.start_link        = start_link;
    rsp_o.just_connected    = conn;
    rsp_o.just_disconnected = disc;
    rsp_o.attempt_number    = ctl_o.attempt_count;
    rsp_o.retry_pending     = ctl_o.retry_armed;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/link_connect_retry_controller_top.sv
// Top level of the link connect retry controller.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+-------------------------------------------------
//   req_i    | in  | valid / ready  | kind, now_ms, link_up
//   rsp_o    | out | valid / ready  | mode, start_link, just_connected,
//            |     |                | just_disconnected, attempt_number, retry_pending
//   cfg      | in  | cfg_we_i       | cfg_idx_i, cfg_wdata_i (write only)
//
// Each request is registered in the input stage on acceptance, then evaluated by the step
// logic, which updates the controller state and loads the result register that drives the
// output. One request per cycle is sustained while the result side is ready. Reset puts
// the controller in disabled mode and loads the register defaults. A stalled result holds
// the input stage; the input stage still accepts while it moves on or is empty, so one
// request may wait behind a held result.
`default_nettype none
module link_connect_retry_controller_top #(
  parameter int unsigned TIME_BITS = lcrc_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  lcrc_req_if.sink                              req_i,
  lcrc_rsp_if.source                            rsp_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [lcrc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lcrc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  lcrc_pkg::cfg_t cfg;

  // Input stage.
  logic                      in_vld_q;
  logic [1:0]                kind_q;
  logic [lcrc_pkg::MS_W-1:0] now_q;
  logic                      link_q;

  // Controller state.
  lcrc_pkg::ctl_t       ctl_q, ctl_d;
  logic [TIME_BITS-1:0] start_time_q, start_time_d;
  logic [TIME_BITS-1:0] retry_time_q, retry_time_d;

  // Result stage.
  logic           out_vld_q;
  lcrc_pkg::rsp_t rsp_q, rsp_d;

  logic advance;
  logic accept;

  lcrc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lcrc_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .cfg_i        (cfg),
    .kind_i       (kind_q),
    .now_ms_i     (now_q),
    .link_up_i    (link_q),
    .ctl_i        (ctl_q),
    .start_time_i (start_time_q),
    .retry_time_i (retry_time_q),
    .ctl_o        (ctl_d),
    .start_time_o (start_time_d),
    .retry_time_o (retry_time_d),
    .rsp_o        (rsp_d)
  );

  // Advance the registered request when the result register is free or drains now.
  assign advance     = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= req_i.kind;
      now_q  <= req_i.now_ms;
      link_q <= req_i.link_up;
    end
  end

  // Commit the state only when a request is evaluated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.mode          <= lcrc_pkg::MODE_DISABLED;
      ctl_q.attempt_count <= 2'd0;
      ctl_q.retry_armed   <= 1'b0;
      start_time_q        <= '0;
      retry_time_q        <= '0;
    end else if (advance) begin
      ctl_q        <= ctl_d;
      start_time_q <= start_time_d;
      retry_time_q <= retry_time_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid             = out_vld_q;
  assign rsp_o.mode              = rsp_q.mode;
  assign rsp_o.start_link        = rsp_q.start_link;
  assign rsp_o.just_connected    = rsp_q.just_connected;
  assign rsp_o.just_disconnected = rsp_q.just_disconnected;
  assign rsp_o.attempt_number    = rsp_q.attempt_number;
  assign rsp_o.retry_pending     = rsp_q.retry_pending;

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the link connect retry controller: table-driven then random requests.
module tb_top;
  import lcrc_pkg::*;

  localparam int unsigned CLK_HALF         = 10;
  localparam int unsigned RESET_CYCLES     = 7;
  localparam int unsigned SETTLE_CYCLES    = 4;      // two-stage pipe plus margin
  localparam int unsigned LONG_HOLD_CYCLES = 64;
  localparam int unsigned PHASES           = 6;
  localparam int unsigned PHASE_ITEMS      = 180;
  localparam int unsigned CYCLE_LIMIT      = 200000;

  // No event decodes to this kind; the block must leave its state alone.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef enum bit {ROW_REQ, ROW_CFG} row_e;

  // One line of the directed table: a request or a register write.
  typedef struct {
    row_e                 op;
    logic [CFG_IDX_W-1:0] idx;
    logic [1:0]           kind;
    logic [MS_W-1:0]      value;   // now_ms of a request, data of a write
    logic                 link;
    bit                   fixed;   // use the typed result instead of the predictor
    rsp_t                 want;
  } step_row_t;

  localparam rsp_t NO_RSP    = '0;
  localparam rsp_t QUIET_OFF = '{MODE_DISABLED, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0};
  localparam rsp_t FIRST_TRY = '{MODE_CONNECTING, 1'b1, 1'b0, 1'b0, 2'd1, 1'b0};
  localparam rsp_t CAME_UP   = '{MODE_ONLINE, 1'b0, 1'b1, 1'b0, 2'd1, 1'b0};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lcrc_req_if req ();
  lcrc_rsp_if rsp ();

  link_connect_retry_controller_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Predicted controller state and its register copy, both at reset values.
  mode_e           lk_mode     = MODE_DISABLED;
  logic [1:0]      lk_attempts = '0;
  logic [MS_W-1:0] lk_started  = '0;
  logic [MS_W-1:0] lk_retry_at = '0;
  logic            lk_armed    = 1'b0;

  logic            cf_enabled    = 1'b0;
  logic [MS_W-1:0] cf_timeout    = TIMEOUT_RST;
  logic [1:0]      cf_max_att    = MAX_ATT_RST;
  logic [MS_W-1:0] cf_first_dly  = FIRST_DLY_RST;
  logic [MS_W-1:0] cf_second_dly = SECOND_DLY_RST;

  rsp_t        pending_rsp [$];   // expected results, oldest first
  int unsigned errors        = 0;
  int unsigned cycles        = 0;
  bit          calm          = 1'b0;  // no idling on either side
  bit          long_hold_req = 1'b0;  // ask the result side for one long stall

  // Directed table. Each special case of the controller gets a line; rows with a
  // typed result are the ones that need no arithmetic to work out.
  step_row_t plan [$] = '{
    // disabled after reset: update, start, retry and unknown kind all do nothing
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'd0,        1'b0, 1'b1, QUIET_OFF},
    '{ROW_REQ, CFG_ENABLED, KIND_START,  32'hFFFF_FFFF, 1'b1, 1'b1, QUIET_OFF},
    '{ROW_REQ, CFG_ENABLED, KIND_RETRY,  32'd0,        1'b1, 1'b1, QUIET_OFF},
    '{ROW_REQ, CFG_ENABLED, KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, QUIET_OFF},
    '{ROW_CFG, CFG_ENABLED, KIND_UPDATE, 32'd1,        1'b0, 1'b0, NO_RSP},
    // full cycle with reset delays: time out one short, then exactly
    '{ROW_REQ, CFG_ENABLED, KIND_START,  32'd100,      1'b0, 1'b1, FIRST_TRY},
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'd15099,    1'b0, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'd15100,    1'b0, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'd23099,    1'b0, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'd23100,    1'b0, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'd38100,    1'b0, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'd68100,    1'b0, 1'b0, NO_RSP},
    // attempts used up: no retry scheduled, only a manual retry helps
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'd83100,    1'b0, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_RETRY,  32'hFFFF_FFFF, 1'b0, 1'b1, FIRST_TRY},
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'd5,        1'b1, 1'b1, CAME_UP},
    // retry while online is ignored; link loss and return across the time wrap
    '{ROW_REQ, CFG_ENABLED, KIND_RETRY,  32'd6,        1'b1, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'hFFFF_F000, 1'b0, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'hFFFF_F001, 1'b1, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'hFFFF_FFF0, 1'b0, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'h0000_1F30, 1'b0, 1'b0, NO_RSP},
    // start restarts the cycle from any mode
    '{ROW_REQ, CFG_ENABLED, KIND_START,  32'd0,        1'b0, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_UNUSED, 32'd1,        1'b1, 1'b0, NO_RSP},
    // zero timeout, zero attempts: time out at once with nothing scheduled
    '{ROW_CFG, CFG_TIMEOUT,    KIND_UPDATE, 32'd0,         1'b0, 1'b0, NO_RSP},
    '{ROW_CFG, CFG_MAX_ATT,    KIND_UPDATE, 32'd0,         1'b0, 1'b0, NO_RSP},
    '{ROW_CFG, CFG_FIRST_DLY,  KIND_UPDATE, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_RSP},
    '{ROW_CFG, CFG_SECOND_DLY, KIND_UPDATE, 32'd0,         1'b0, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_START,  32'd7,        1'b0, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'd7,        1'b0, 1'b0, NO_RSP},
    // controller disabled: start drops to disabled and updates stay there
    '{ROW_CFG, CFG_ENABLED, KIND_UPDATE, 32'd0,        1'b0, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_START,  32'd9,        1'b1, 1'b0, NO_RSP},
    '{ROW_REQ, CFG_ENABLED, KIND_UPDATE, 32'd9,        1'b1, 1'b0, NO_RSP}
  };

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Begin one connect attempt of the current cycle.
  function automatic void open_attempt(logic [MS_W-1:0] now);
    lk_attempts = lk_attempts + 2'd1;
    lk_started  = now;
    lk_armed    = 1'b0;
    lk_retry_at = '0;
    lk_mode     = MODE_CONNECTING;
  endfunction

  // Advance the predicted controller by one request and return its result.
  function automatic rsp_t step_link_controller(logic [1:0] kind, logic [MS_W-1:0] now,
                                                logic link);
    rsp_t            r;
    logic [MS_W-1:0] waited;
    logic [MS_W-1:0] past_retry;
    r          = '0;
    waited     = now - lk_started;
    past_retry = now - lk_retry_at;
    case (kind)
      KIND_START: begin
        if (!cf_enabled) begin
          lk_mode = MODE_DISABLED;
        end else begin
          lk_attempts = '0;
          open_attempt(now);
          r.start_link = 1'b1;
        end
      end
      KIND_RETRY: begin
        if (lk_mode == MODE_OFFLINE) begin
          lk_attempts = '0;
          open_attempt(now);
          r.start_link = 1'b1;
        end
      end
      KIND_UPDATE: begin
        case (lk_mode)
          MODE_CONNECTING: begin
            if (link) begin
              lk_mode          = MODE_ONLINE;
              r.just_connected = 1'b1;
            end else if (waited >= cf_timeout) begin
              lk_mode  = MODE_OFFLINE;
              lk_armed = lk_attempts < cf_max_att;
              if (!lk_armed) begin
                lk_retry_at = '0;
              end else begin
                // first attempt waits the first delay, all later ones the second
                lk_retry_at = now + ((lk_attempts <= 2'd1) ? cf_first_dly : cf_second_dly);
              end
            end
          end
          MODE_ONLINE: begin
            if (!link) begin
              lk_mode             = MODE_OFFLINE;
              r.just_disconnected = 1'b1;
              lk_attempts         = '0;
              lk_retry_at         = now + cf_first_dly;
              lk_armed            = 1'b1;
            end
          end
          MODE_OFFLINE: begin
            if (link) begin
              lk_mode          = MODE_ONLINE;
              r.just_connected = 1'b1;
            end else if (lk_armed && !past_retry[MS_W-1]) begin
              // deadline reached while the wrapped distance is under half the range
              open_attempt(now);
              r.start_link = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.mode           = lk_mode;
    r.attempt_number = lk_attempts;
    r.retry_pending  = lk_armed;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic logic [MS_W-1:0] pick_ms();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  // Write one register at the next edge and mirror it into the predictor.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLED:    cf_enabled    = data[0];
      CFG_TIMEOUT:    cf_timeout    = data;
      CFG_MAX_ATT:    cf_max_att    = data[1:0];
      CFG_FIRST_DLY:  cf_first_dly  = data;
      CFG_SECOND_DLY: cf_second_dly = data;
      default: ;
    endcase
  endtask

  // Drop the request valid, drain every outstanding result and let the pipe empty.
  task automatic settle_link();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one request, maybe after an idle burst, and hold it until accepted.
  task automatic offer_request(logic [1:0] kind, logic [MS_W-1:0] now, logic link,
                               bit fixed, rsp_t want);
    rsp_t predicted;
    @(negedge clk);
    if (!calm && $urandom_range(0, 6) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    req.valid   <= 1'b1;
    req.kind    <= kind;
    req.now_ms  <= now;
    req.link_up <= link;
    do @(posedge clk); while (!req.ready);
    predicted = step_link_controller(kind, now, link);
    pending_rsp.push_back(fixed ? want : predicted);
  endtask

  // Result side ready: random stall bursts, one long hold on request, none when calm.
  initial begin : result_ready
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        rsp.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk) begin : result_check
    rsp_t want;
    if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        $error("result with no request outstanding: mode %0d", rsp.mode);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("mode", want.mode, rsp.mode);
        check_field("start_link", want.start_link, rsp.start_link);
        check_field("just_connected", want.just_connected, rsp.just_connected);
        check_field("just_disconnected", want.just_disconnected, rsp.just_disconnected);
        check_field("attempt_number", want.attempt_number, rsp.attempt_number);
        check_field("retry_pending", want.retry_pending, rsp.retry_pending);
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [MS_W-1:0] wall_ms;
    logic            link_level;
    logic [1:0]      kind;
    int unsigned     pick;

    // Hold every input at a known value through reset.
    req.valid   = 1'b0;
    req.kind    = KIND_UPDATE;
    req.now_ms  = '0;
    req.link_up = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_ENABLED;
    cfg_wdata   = '0;
    rst_n       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; write registers only once the block is idle.
    foreach (plan[i]) begin
      if (plan[i].op == ROW_CFG) begin
        settle_link();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        offer_request(plan[i].kind, plan[i].value, plan[i].link, plan[i].fixed, plan[i].want);
      end
    end

    // Random phases. Time mostly advances in small steps against small timeouts and
    // delays so that attempts, timeouts, losses and retries all happen often; rare
    // jumps to a random time exercise every bit of now_ms and the wrap.
    for (int p = 0; p < PHASES; p++) begin
      settle_link();
      calm = (p == PHASES - 1);
      write_reg(CFG_ENABLED, (p == 0 || calm) ? 1 : ($urandom_range(0, 3) != 0));
      write_reg(CFG_TIMEOUT, (p == 2) ? '1 : pick_ms());
      write_reg(CFG_MAX_ATT, (p == 2) ? 3 : $urandom_range(0, 3));
      write_reg(CFG_FIRST_DLY, (p == 4) ? '0 : pick_ms());
      write_reg(CFG_SECOND_DLY, (p == 4) ? '1 : pick_ms());
      wall_ms    = (p == 0) ? 32'hFFFF_FF00 : $urandom();
      link_level = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stall the result side long enough to back up the input
        if (p == 1 && n == 40) long_hold_req = 1'b1;
        // pause the requests until everything has come back
        if (p == 3 && n == 100) settle_link();
        pick = $urandom_range(0, 99);
        kind = (pick < 4)  ? KIND_START  :
               (pick < 10) ? KIND_RETRY  :
               (pick < 12) ? KIND_UNUSED : KIND_UPDATE;
        if ($urandom_range(0, 7) == 0) link_level = !link_level;
        if ($urandom_range(0, 39) == 0) begin
          wall_ms = $urandom();
        end else begin
          wall_ms = wall_ms + $urandom_range(0, 60);
        end
        offer_request(kind, wall_ms, link_level, 1'b0, NO_RSP);
      end
    end

    settle_link();
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/lcrc_pkg.sv
hw/rtl/lcrc_req_if.sv
hw/rtl/lcrc_rsp_if.sv
hw/rtl/lcrc_cfg_regs.sv
hw/rtl/lcrc_step.sv
hw/rtl/link_connect_retry_controller_top.sv
bench/tb_top.sv
